>>> rtl/lotl_pkg.sv
`timescale 1ns / 1ps

package lotl_pkg;

   // table geometry
   localparam int MAX_LINES = 1024;
   localparam int IDX_W     = $clog2(MAX_LINES);
   localparam int CNT_W     = $clog2(MAX_LINES + 1);
   localparam int OFS_W     = 32;

   // operation codes
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_ORDER = 2'd2;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_RESULT
   } lotl_state_type;

   // access request toward the offset memory
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [OFS_W-1:0] wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } lotl_ram_req_type;

endpackage

>>> rtl/lotl_line_ram.sv
`timescale 1ns / 1ps

module lotl_line_ram (
   input  logic                           clock,
   input  lotl_pkg::lotl_ram_req_type     ram_req,
   output logic [lotl_pkg::OFS_W-1:0]     rd_data
);

   logic [lotl_pkg::OFS_W-1:0] mem [lotl_pkg::MAX_LINES];
   logic [lotl_pkg::OFS_W-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/line_offset_table_lookup.sv
`timescale 1ns / 1ps

// Line-start offset table with binary-search lookup.
// Input words arrive on req_: tuser carries the operation (lookup, append,
// clear), tdata the byte cursor. Each word yields exactly one result word on
// rsp_: tdata holds line and column for a lookup, else zero; tuser the status.
// For append and clear the sequencer goes from idle to the result state; a
// lookup on more than one entry first runs search states, one offset memory
// read per halving step. The result state loads the output register, from
// which rsp_tvalid rises, and returns to idle, where the next word goes in.
// Only one word is in work at a time; req_tready is high while the
// sequencer is idle, and a new word may be taken while the previous result
// still waits in the output register.
// When the receiver stalls, the result holds in the output register and a
// finished search waits until that register frees up.
// csr_ writes the first line number (signed, reset 1); it is always ready
// and should be written only while no word is in work.
// Synchronous reset empties the table back to its single zero entry at
// offset 0 and drops any pending result; no clearing pass is needed.
module line_offset_table_lookup (
   input  logic                        clock,
   input  logic                        reset,
   // slave side
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [31:0]                 req_tdata,  // [31:0] cursor
   input  logic [1:0]                  req_tuser,  // [1:0] operation
   // master side
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [63:0]                 rsp_tdata,  // [31:0] line, [63:32] column
   output logic [1:0]                  rsp_tuser,  // [1:0] status
   // configuration
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic signed [31:0]          csr_data
);

   localparam int IDX_W = lotl_pkg::IDX_W;
   localparam int CNT_W = lotl_pkg::CNT_W;
   localparam int OFS_W = lotl_pkg::OFS_W;

   lotl_pkg::lotl_state_type state_ff, state_in;

   logic signed [31:0]  first_line_ff, first_line_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [OFS_W-1:0]    last_ff, last_in;
   logic [1:0]          op_ff, op_in;
   logic [OFS_W-1:0]    cur_ff, cur_in;
   logic [1:0]          status_ff, status_in;
   logic [IDX_W-1:0]    lo_ff, lo_in;
   logic [IDX_W-1:0]    hi_ff, hi_in;
   logic [IDX_W-1:0]    mid_ff, mid_in;
   logic [OFS_W-1:0]    lo_val_ff, lo_val_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [63:0]         rsp_data_ff, rsp_data_in;
   logic [1:0]          rsp_user_ff, rsp_user_in;

   lotl_pkg::lotl_ram_req_type ram_req;
   logic [OFS_W-1:0]    rd_data;

   logic                accept;
   logic                out_free;
   logic [IDX_W-1:0]    hi0;
   logic [IDX_W:0]      mid0_wide;
   logic                le;
   logic [IDX_W-1:0]    lo_n, hi_n;
   logic [OFS_W-1:0]    val_n;
   logic [IDX_W:0]      span_wide;
   logic [IDX_W:0]      mid_n_wide;
   logic [31:0]         line_sum;
   logic [OFS_W-1:0]    col_diff;

   lotl_line_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == lotl_pkg::S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   // first search step from a fresh table bound
   assign hi0       = IDX_W'(count_ff - CNT_W'(1));
   assign mid0_wide = ({1'b0, hi0} + (IDX_W+1)'(1)) >> 1;

   // one halving step of the search
   assign le         = (rd_data <= cur_ff);
   assign lo_n       = le ? mid_ff : lo_ff;
   assign hi_n       = le ? hi_ff : (mid_ff - IDX_W'(1));
   assign val_n      = le ? rd_data : lo_val_ff;
   assign span_wide  = ({1'b0, hi_n} - {1'b0, lo_n} + (IDX_W+1)'(1)) >> 1;
   assign mid_n_wide = {1'b0, lo_n} + span_wide;

   // result arithmetic
   assign line_sum = 32'(lo_ff) + first_line_ff;
   assign col_diff = cur_ff - lo_val_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lotl_pkg::S_IDLE: begin
            if (accept) begin
               if (req_tuser == lotl_pkg::OP_LOOKUP && hi0 != '0) begin
                  state_in = lotl_pkg::S_SEARCH;
               end else begin
                  state_in = lotl_pkg::S_RESULT;
               end
            end
         end
         lotl_pkg::S_SEARCH: begin
            if (!(lo_n < hi_n)) begin
               state_in = lotl_pkg::S_RESULT;
            end
         end
         lotl_pkg::S_RESULT: begin
            if (out_free) begin
               state_in = lotl_pkg::S_IDLE;
            end
         end
         default: state_in = lotl_pkg::S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      first_line_in = first_line_ff;
      count_in      = count_ff;
      last_in       = last_ff;
      op_in         = op_ff;
      cur_in        = cur_ff;
      status_in     = status_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      lo_val_in     = lo_val_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      ram_req       = '0;

      if (csr_valid && csr_ready) begin
         first_line_in = csr_data;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         lotl_pkg::S_IDLE: begin
            if (accept) begin
               op_in     = req_tuser;
               cur_in    = req_tdata;
               status_in = lotl_pkg::ST_OK;
               lo_in     = '0;
               hi_in     = hi0;
               lo_val_in = '0;
               mid_in    = mid0_wide[IDX_W-1:0];
               unique case (req_tuser)
                  lotl_pkg::OP_LOOKUP: begin
                     // entry 0 is implied, so only probe when more exist
                     if (hi0 != '0) begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = mid0_wide[IDX_W-1:0];
                     end
                  end
                  lotl_pkg::OP_APPEND: begin
                     priority if (count_ff == CNT_W'(lotl_pkg::MAX_LINES)) begin
                        status_in = lotl_pkg::ST_FULL;
                     end else if (req_tdata <= last_ff) begin
                        status_in = lotl_pkg::ST_ORDER;
                     end else begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = count_ff[IDX_W-1:0];
                        ram_req.wr_data = req_tdata;
                        count_in        = count_ff + CNT_W'(1);
                        last_in         = req_tdata;
                     end
                  end
                  lotl_pkg::OP_CLEAR: begin
                     count_in = CNT_W'(1);
                     last_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         lotl_pkg::S_SEARCH: begin
            lo_in     = lo_n;
            hi_in     = hi_n;
            lo_val_in = val_n;
            mid_in    = mid_n_wide[IDX_W-1:0];
            if (lo_n < hi_n) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = mid_n_wide[IDX_W-1:0];
            end
         end
         lotl_pkg::S_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               if (op_ff == lotl_pkg::OP_LOOKUP) begin
                  rsp_data_in = {col_diff, line_sum};
               end else begin
                  rsp_data_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lotl_pkg::S_IDLE;
         first_line_ff <= 32'sd1;
         count_ff      <= CNT_W'(1);
         last_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_line_ff <= first_line_in;
         count_ff      <= count_in;
         last_ff       <= last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      cur_ff      <= cur_in;
      status_ff   <= status_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      lo_val_ff   <= lo_val_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // table size stays within one entry and the capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(1)) && (count_ff <= CNT_W'(lotl_pkg::MAX_LINES)))
      else $error("entry count out of range");

   // a search step always has a probe strictly above the low bound
   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lotl_pkg::S_SEARCH) |-> (lo_ff < hi_ff) && (mid_ff > lo_ff)
         && (mid_ff <= hi_ff))
      else $error("search window broken");

   // one word in work at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("input taken while busy");

   // result loads only into a free output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("pending result overwritten");

endmodule
